// File: src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GDR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define GDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/gdr_pkg.sv
// Package: constants and codes for the grid DDA ray caster
`timescale 1ns / 1ps
package gdr_pkg;
    localparam int MAP_W_DEF = 32;
    localparam int MAP_H_DEF = 32;
    localparam logic [31:0] DELTA_MAX = 32'hFFFF_FFFF;
    localparam logic [19:0] PERP_MAX = 20'hF_FFFF;
    localparam logic [5:0] MAP_DIM_RST = 6'd32;

    typedef enum logic [1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } t_op;
endpackage

// File: src/grid_dda_ray_caster.sv
// Top level: grid DDA ray caster with wall map, shared divider and shift-add multiplier
`timescale 1ns / 1ps
`include "assert_macros.svh"

// After reset the block sweeps the wall map to all walls, one cell per cycle,
// and holds busy meanwhile. A write item goes straight into the map and leaves
// the block idle. A cast runs the shared restoring divider once per nonzero
// direction component (a zero component skips the division), the shared
// shift-add multiplier for each side distance and for the wall offset, then
// the first step and, per cell walked, a map read, a wall test and the next
// step. The result is shown for one cycle with o_valid; the receiver cannot
// stall it.
module grid_dda_ray_caster
    import gdr_pkg::*;
#(
    parameter int MAP_W = MAP_W_DEF,
    parameter int MAP_H = MAP_H_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [4:0]  i_cell_x,
    input  logic [4:0]  i_cell_y,
    input  logic        i_cell_wall,
    input  logic [16:0] i_pos_x,
    input  logic [16:0] i_pos_y,
    input  logic signed [15:0] i_ray_dir_x,
    input  logic signed [15:0] i_ray_dir_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    output logic        o_valid,
    output logic [19:0] o_wall_dist,
    output logic        o_side,
    output logic [11:0] o_wall_frac
);
    localparam int XW = (MAP_W > 1) ? $clog2(MAP_W) : 1;
    localparam int YW = (MAP_H > 1) ? $clog2(MAP_H) : 1;
    localparam int AW = XW + YW;
    localparam int DEPTH = MAP_H << XW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_MUL, S_STEP, S_READ, S_TEST, S_MULO
    } t_state;

    t_state       r_state;
    logic [AW-1:0] r_clr;
    logic [5:0]   r_map_width, r_map_height;

    // wall map
    logic         mem [DEPTH];
    logic         r_rd;
    logic         mem_we, mem_wd;
    logic [AW-1:0] mem_wa, rd_addr;

    // ray state
    logic [16:0]  r_px, r_py;
    logic         r_negx, r_negy;
    logic [15:0]  r_magx, r_magy;
    logic [31:0]  r_dlx, r_dly;
    logic [39:0]  r_sx, r_sy, r_perp;
    logic signed [6:0] r_mx, r_my;
    logic         r_side;
    logic         r_ax;

    // shared divider
    logic [15:0]  r_rem;
    logic [4:0]   r_dcnt;
    logic [31:0]  r_quo;
    logic [16:0]  div_t;
    logic         div_ge;
    logic [15:0]  div_mag;

    // shared multiplier
    logic [55:0]  r_ma, r_acc, n_acc;
    logic [15:0]  r_mb;
    logic [3:0]   r_mcnt;

    logic         accept, cast_acc;
    logic [15:0]  in_magx, in_magy;
    logic [5:0]   w_eff, h_eff;
    logic         blocked, step_x;
    logic [39:0]  n_sx, n_sy;
    logic [11:0]  off, n_wf;
    logic [12:0]  fterm_x, fterm_y;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign cast_acc    = accept && (i_operation == OP_CAST);
    assign in_magx = i_ray_dir_x[15] ? 16'(17'h10000 - {1'b0, i_ray_dir_x}) : i_ray_dir_x;
    assign in_magy = i_ray_dir_y[15] ? 16'(17'h10000 - {1'b0, i_ray_dir_y}) : i_ray_dir_y;

    assign w_eff = (r_map_width  < 6'(MAP_W)) ? r_map_width  : 6'(MAP_W);
    assign h_eff = (r_map_height < 6'(MAP_H)) ? r_map_height : 6'(MAP_H);
    assign blocked = r_mx[6] || r_my[6] || (r_mx[5:0] >= w_eff) || (r_my[5:0] >= h_eff) || r_rd;
    assign rd_addr = {r_my[YW-1:0], r_mx[XW-1:0]};

    assign div_mag = r_ax ? r_magy : r_magx;
    assign div_t   = {r_rem, (r_dcnt == 5'd30)};
    assign div_ge  = div_t >= {1'b0, div_mag};

    assign n_acc = r_acc + (r_mb[0] ? r_ma : 56'd0);

    assign step_x = r_sx < r_sy;
    assign n_sx   = r_sx + {8'd0, r_dlx};
    assign n_sy   = r_sy + {8'd0, r_dly};

    assign fterm_x = r_negx ? {1'b0, r_px[11:0]} : 13'(13'd4096 - {1'b0, r_px[11:0]});
    assign fterm_y = r_negy ? {1'b0, r_py[11:0]} : 13'(13'd4096 - {1'b0, r_py[11:0]});

    assign off  = n_acc[29:18];
    assign n_wf = r_side ? (r_negx ? r_px[11:0] - off : r_px[11:0] + off)
                         : (r_negy ? r_py[11:0] - off : r_py[11:0] + off);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = 1'b1;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (accept && i_operation == OP_WRITE &&
                     {1'b0, i_cell_x} < 6'(MAP_W) && {1'b0, i_cell_y} < 6'(MAP_H)) begin
            mem_we = 1'b1;
            mem_wa = {i_cell_y[YW-1:0], i_cell_x[XW-1:0]};
            mem_wd = i_cell_wall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= MAP_DIM_RST;
            r_map_height <= MAP_DIM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // walk step: cross the nearer grid line
    task automatic do_step();
        if (step_x) begin
            r_perp <= r_sx;
            r_sx   <= n_sx;
            r_mx   <= r_negx ? r_mx - 7'sd1 : r_mx + 7'sd1;
            r_side <= 1'b0;
        end else begin
            r_perp <= r_sy;
            r_sy   <= n_sy;
            r_my   <= r_negy ? r_my - 7'sd1 : r_my + 7'sd1;
            r_side <= 1'b1;
        end
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cast_acc) begin
                        r_px   <= i_pos_x;
                        r_py   <= i_pos_y;
                        r_negx <= i_ray_dir_x[15];
                        r_negy <= i_ray_dir_y[15];
                        r_magx <= in_magx;
                        r_magy <= in_magy;
                        r_mx   <= {2'b00, i_pos_x[16:12]};
                        r_my   <= {2'b00, i_pos_y[16:12]};
                        r_dlx  <= DELTA_MAX;
                        r_dly  <= DELTA_MAX;
                        r_ax   <= 1'b0;
                        r_rem  <= '0;
                        r_dcnt <= 5'd30;
                        r_quo  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_mag == 16'd0) begin
                        r_dcnt <= 5'd30;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        if (r_ax) begin
                            r_ma    <= {24'd0, r_dlx};
                            r_mb    <= {3'd0, fterm_x};
                            r_acc   <= '0;
                            r_mcnt  <= '0;
                            r_ax    <= 1'b0;
                            r_state <= S_MUL;
                        end else begin
                            r_ax <= 1'b1;
                        end
                    end else begin
                        r_rem <= div_ge ? 16'(div_t - {1'b0, div_mag}) : div_t[15:0];
                        r_quo <= {r_quo[30:0], div_ge};
                        r_dcnt <= r_dcnt - 5'd1;
                        if (r_dcnt == 5'd0) begin
                            r_dcnt <= 5'd30;
                            r_rem  <= '0;
                            r_quo  <= '0;
                            if (r_ax) begin
                                r_dly   <= {r_quo[30:0], div_ge};
                                r_ma    <= {24'd0, r_dlx};
                                r_mb    <= {3'd0, fterm_x};
                                r_acc   <= '0;
                                r_mcnt  <= '0;
                                r_ax    <= 1'b0;
                                r_state <= S_MUL;
                            end else begin
                                r_dlx <= {r_quo[30:0], div_ge};
                                r_ax  <= 1'b1;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_acc  <= n_acc;
                    r_ma   <= {r_ma[54:0], 1'b0};
                    r_mb   <= {1'b0, r_mb[15:1]};
                    r_mcnt <= r_mcnt + 4'd1;
                    if (r_mcnt == 4'd15) begin
                        r_acc  <= '0;
                        r_mcnt <= '0;
                        if (r_ax) begin
                            r_sy    <= n_acc[51:12];
                            r_state <= S_STEP;
                        end else begin
                            r_sx <= n_acc[51:12];
                            r_ma <= {24'd0, r_dly};
                            r_mb <= {3'd0, fterm_y};
                            r_ax <= 1'b1;
                        end
                    end
                end
                S_STEP: begin
                    do_step();
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (blocked) begin
                        r_ma    <= {16'd0, r_perp};
                        r_mb    <= r_side ? r_magx : r_magy;
                        r_acc   <= '0;
                        r_mcnt  <= '0;
                        r_state <= S_MULO;
                    end else begin
                        do_step();
                        r_state <= S_READ;
                    end
                end
                S_MULO: begin
                    r_acc  <= n_acc;
                    r_ma   <= {r_ma[54:0], 1'b0};
                    r_mb   <= {1'b0, r_mb[15:1]};
                    r_mcnt <= r_mcnt + 4'd1;
                    if (r_mcnt == 4'd15) begin
                        o_valid     <= 1'b1;
                        o_wall_dist <= (|r_perp[39:24]) ? PERP_MAX : r_perp[23:4];
                        o_side      <= r_side;
                        o_wall_frac <= n_wf;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `GDR_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid)
    `GDR_ASSERT_NEXT(a_cast_busy, cast_acc, busy)
    `GDR_ASSERT_NOW(a_valid_from_mul, o_valid, $past(r_state) == S_MULO)
    `GDR_ASSERT_NOW(a_no_write_busy, mem_we && r_state != S_CLEAR, !busy)
endmodule
